FILE: rtl/core/bus_frame_header_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bus frame header parser checks.
// ----------------------------------------------------------------------------
`ifndef BUS_FRAME_HEADER_PARSER_MACROS_SVH
`define BUS_FRAME_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define BFHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfhp check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define BFHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfhp check failed");

`endif

FILE: rtl/core/bfhp_pkg.sv
// ----------------------------------------------------------------------------
// bfhp_pkg
// Shared widths, register indexes, frame positions and types of the bus
// frame header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfhp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 24;
    localparam int POS_W    = 9;
    localparam int PRIO_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd1;

    // Configuration reset values
    localparam logic [ADDR_W-1:0] NODE_ADDRESS_RST = 24'h010203;
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h03;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_IDLE     = 9'd0;
    localparam logic [POS_W-1:0] POS_MARKER   = 9'd1;
    localparam logic [POS_W-1:0] POS_SENDER_0 = 9'd2;
    localparam logic [POS_W-1:0] POS_SENDER_1 = 9'd3;
    localparam logic [POS_W-1:0] POS_SENDER_2 = 9'd4;
    localparam logic [POS_W-1:0] POS_RECV_0   = 9'd5;
    localparam logic [POS_W-1:0] POS_RECV_1   = 9'd6;
    localparam logic [POS_W-1:0] POS_RECV_2   = 9'd7;
    localparam logic [POS_W-1:0] POS_TYPE     = 9'd8;
    localparam logic [POS_W-1:0] POS_LENGTH   = 9'd9;
    localparam logic [POS_W-1:0] POS_FLAGS    = 9'd10;

    // Flags byte bit positions
    localparam int FLAG_PHYS_BIT   = 4;
    localparam int FLAG_ANSWER_BIT = 5;

    typedef struct packed {
        logic [ADDR_W-1:0] node_address;
        logic [BYTE_W-1:0] start_marker;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  frame_position;
        logic              bad_marker;
        logic              header_done;
        logic              payload_valid;
        logic              frame_end;
        logic              id_match;
        logic [ADDR_W-1:0] sender_address;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_length;
        logic              address_physical;
        logic              answer_expected;
        logic [PRIO_W-1:0] priority_level;
    } t_result;

    // Count of ones in the three priority bits of the flags byte
    function automatic logic [PRIO_W-1:0] prio_count(input logic [BYTE_W-1:0] flags);
        prio_count = PRIO_W'(flags[0]) + PRIO_W'(flags[1]) + PRIO_W'(flags[2]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bfhp_ifs.sv
// ----------------------------------------------------------------------------
// bfhp channel interfaces
// Valid/ready channels for received bytes, configuration writes and
// parsed results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfhp_byte_if
    import bfhp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] bus_byte;

    modport source (output valid, output bus_byte, input ready);
    modport sink   (input valid, input bus_byte, output ready);
endinterface

interface bfhp_cfg_if
    import bfhp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bfhp_result_if
    import bfhp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  frame_position;
    logic              bad_marker;
    logic              header_done;
    logic              payload_valid;
    logic              frame_end;
    logic              id_match;
    logic [ADDR_W-1:0] sender_address;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] payload_length;
    logic              address_physical;
    logic              answer_expected;
    logic [PRIO_W-1:0] priority_level;

    modport source (
        output valid, input ready,
        output frame_position, bad_marker, header_done, payload_valid, frame_end,
        output id_match, sender_address, frame_type, payload_length,
        output address_physical, answer_expected, priority_level
    );
    modport sink (
        input valid, output ready,
        input frame_position, bad_marker, header_done, payload_valid, frame_end,
        input id_match, sender_address, frame_type, payload_length,
        input address_physical, answer_expected, priority_level
    );
endinterface

`default_nettype wire

FILE: rtl/core/bfhp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bfhp_cfg_regs
// Node address and start marker registers, written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfhp_cfg_regs
    import bfhp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [ADDR_W-1:0]    i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Decode the index; writes beyond the register list drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_address <= NODE_ADDRESS_RST;
            r_cfg.start_marker <= START_MARKER_RST;
        end else if (i_wr_en) begin
            if (i_wr_index == CFG_NODE_ADDRESS) begin
                r_cfg.node_address <= i_wr_data;
            end else if (i_wr_index == CFG_START_MARKER) begin
                r_cfg.start_marker <= i_wr_data[BYTE_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/bfhp_parse.sv
// ----------------------------------------------------------------------------
// bfhp_parse
// Frame position counter and header field registers; computes the result
// of one byte in a single pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfhp_parse
    import bfhp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_bus_byte,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    logic [POS_W-1:0]  r_byte_position, n_byte_position;
    logic [ADDR_W-1:0] r_sender, n_sender;
    logic [ADDR_W-1:0] r_receiver, n_receiver;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_length, n_length;
    logic              r_phys, n_phys;
    logic              r_answer, n_answer;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic              r_match, n_match;

    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  end_pos;
    logic              bad;
    logic              hdr;
    logic              pay;
    logic              fend;
    logic              match_shown;

    // Decode the byte by its position in the frame
    always_comb begin
        n_sender   = r_sender;
        n_receiver = r_receiver;
        n_type     = r_type;
        n_length   = r_length;
        n_phys     = r_phys;
        n_answer   = r_answer;
        n_prio     = r_prio;
        bad        = 1'b0;
        hdr        = 1'b0;
        pay        = 1'b0;
        fend       = 1'b0;
        match_shown = r_match;
        pos        = r_byte_position + POS_W'(1);
        end_pos    = POS_W'(r_length) + POS_FLAGS;

        priority if (pos == POS_MARKER) begin
            bad = (i_bus_byte != i_cfg.start_marker);
        end else if (pos == POS_SENDER_0) begin
            n_sender[23:16] = i_bus_byte;
        end else if (pos == POS_SENDER_1) begin
            n_sender[15:8] = i_bus_byte;
        end else if (pos == POS_SENDER_2) begin
            n_sender[7:0] = i_bus_byte;
        end else if (pos == POS_RECV_0) begin
            n_receiver[23:16] = i_bus_byte;
        end else if (pos == POS_RECV_1) begin
            n_receiver[15:8] = i_bus_byte;
        end else if (pos == POS_RECV_2) begin
            n_receiver[7:0] = i_bus_byte;
            if ({r_receiver[23:8], i_bus_byte} == i_cfg.node_address) begin
                match_shown = 1'b1;
            end
        end else if (pos == POS_TYPE) begin
            n_type = i_bus_byte;
        end else if (pos == POS_LENGTH) begin
            n_length = i_bus_byte;
        end else if (pos >= POS_FLAGS) begin
            if (pos == POS_FLAGS) begin
                n_phys   = i_bus_byte[FLAG_PHYS_BIT];
                n_answer = i_bus_byte[FLAG_ANSWER_BIT];
                n_prio   = prio_count(i_bus_byte);
                hdr      = 1'b1;
            end else begin
                pay = 1'b1;
            end
            fend = (pos >= end_pos);
        end

        // Drop back to idle on a bad marker or the last byte
        if (bad || fend) begin
            n_byte_position = POS_IDLE;
            n_match         = 1'b0;
        end else begin
            n_byte_position = pos;
            n_match         = match_shown;
        end
    end

    // Hold frame state; advance only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= POS_IDLE;
            r_sender        <= '0;
            r_receiver      <= '0;
            r_type          <= '0;
            r_length        <= '0;
            r_phys          <= 1'b0;
            r_answer        <= 1'b0;
            r_prio          <= '0;
            r_match         <= 1'b0;
        end else if (i_accept) begin
            r_byte_position <= n_byte_position;
            r_sender        <= n_sender;
            r_receiver      <= n_receiver;
            r_type          <= n_type;
            r_length        <= n_length;
            r_phys          <= n_phys;
            r_answer        <= n_answer;
            r_prio          <= n_prio;
            r_match         <= n_match;
        end
    end

    // Assemble the result of this byte
    always_comb begin
        o_result.frame_position   = n_byte_position;
        o_result.bad_marker       = bad;
        o_result.header_done      = hdr;
        o_result.payload_valid    = pay;
        o_result.frame_end        = fend;
        o_result.id_match         = match_shown;
        o_result.sender_address   = n_sender;
        o_result.frame_type       = n_type;
        o_result.payload_length   = n_length;
        o_result.address_physical = n_phys;
        o_result.answer_expected  = n_answer;
        o_result.priority_level   = n_prio;
    end

endmodule

`default_nettype wire

FILE: rtl/core/bfhp_out_reg.sv
// ----------------------------------------------------------------------------
// bfhp_out_reg
// Result register with valid/ready; reloads in the cycle it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfhp_out_reg
    import bfhp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_can_load,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held request leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Capture the result; hold it while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/core/bus_frame_header_parser.sv
// ----------------------------------------------------------------------------
// bus_frame_header_parser
// Tracks each received bus byte's place in a frame and decodes the header.
//
// Usage:
//   i_byte   - one received bus byte per request.
//   i_cfg    - register writes: index 0 node address, index 1 start marker;
//              always ready outside reset, other indexes are ignored.
//   o_result - one result per byte: frame position, marker/header/payload/
//              end flags, address match and the stored header fields.
// Output: the result is registered and shown in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless the result side stalls; the position
//   decode, one 24-bit address compare and one 9-bit end compare fit between
//   the frame registers and the result register.
// Reset: counter, match flag and header fields clear to zero, node address
//   returns to 0x010203 and start marker to 0x03.
// Stall: while a result waits unread and the receiver holds ready low,
//   i_byte.ready is low; a byte is still taken in the cycle the held result
//   is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bus_frame_header_parser
    import bfhp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    bfhp_byte_if.sink     i_byte,
    bfhp_cfg_if.sink      i_cfg,
    bfhp_result_if.source o_result
);

    t_cfg    cfg;
    t_result parse_result;
    t_result held_result;
    logic    can_load;
    logic    byte_accept;

    // Accept a byte whenever the result register can take it
    assign i_byte.ready = i_rst_n && can_load;
    assign byte_accept  = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = i_rst_n;

    bfhp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid && i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    bfhp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (byte_accept),
        .i_bus_byte (i_byte.bus_byte),
        .i_cfg      (cfg),
        .o_result   (parse_result)
    );

    bfhp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (byte_accept),
        .i_result   (parse_result),
        .i_ready    (o_result.ready),
        .o_can_load (can_load),
        .o_valid    (o_result.valid),
        .o_result   (held_result)
    );

    // Drive the result channel fields
    assign o_result.frame_position   = held_result.frame_position;
    assign o_result.bad_marker       = held_result.bad_marker;
    assign o_result.header_done      = held_result.header_done;
    assign o_result.payload_valid    = held_result.payload_valid;
    assign o_result.frame_end        = held_result.frame_end;
    assign o_result.id_match         = held_result.id_match;
    assign o_result.sender_address   = held_result.sender_address;
    assign o_result.frame_type       = held_result.frame_type;
    assign o_result.payload_length   = held_result.payload_length;
    assign o_result.address_physical = held_result.address_physical;
    assign o_result.answer_expected  = held_result.answer_expected;
    assign o_result.priority_level   = held_result.priority_level;

endmodule

`default_nettype wire

FILE: rtl/core/bfhp_checker.sv
// ----------------------------------------------------------------------------
// bfhp_checker
// Port-level checks of the bus frame header parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bus_frame_header_parser_macros.svh"

module bfhp_checker
    import bfhp_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [POS_W-1:0] i_frame_position,
    input wire logic             i_bad_marker,
    input wire logic             i_header_done,
    input wire logic             i_payload_valid,
    input wire logic             i_frame_end
);

    // A dropped or finished frame leaves the counter at idle
    `BFHP_ASSERT_NOW(a_end_clears_pos, i_out_valid && (i_bad_marker || i_frame_end), i_frame_position == POS_IDLE)

    // The flags byte sits at position ten unless it also ends the frame
    `BFHP_ASSERT_NOW(a_hdr_pos, i_out_valid && i_header_done && !i_frame_end, i_frame_position == POS_FLAGS)

    // Payload bytes never share a request with a bad marker or the flags byte
    `BFHP_ASSERT_NOW(a_pay_excl, i_out_valid && i_payload_valid, !i_header_done && !i_bad_marker)

    // An empty result register always takes the next byte
    `BFHP_ASSERT_NOW(a_empty_ready, !i_out_valid, i_in_ready)

    // A stalled result stays put
    `BFHP_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_frame_position))

endmodule

bind bus_frame_header_parser bfhp_checker u_bfhp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_byte.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_frame_position (o_result.frame_position),
    .i_bad_marker     (o_result.bad_marker),
    .i_header_done    (o_result.header_done),
    .i_payload_valid  (o_result.payload_valid),
    .i_frame_end      (o_result.frame_end)
);

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - bus frame header parser testbench
// Feeds bus bytes through the byte channel. A short table of directed frames
// comes first, then randomized frames in several node address and start
// marker settings. Each parse result is checked field by field against a
// behavioral copy of the parser. Random idle gaps sit on both sides.
// ----------------------------------------------------------------------------

module tb;
    import bfhp_pkg::*;

    // Unused register indexes, writes to these must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int BYTES_PER_PHASE = 175;
    localparam int MAX_PRINTS      = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] bus_byte;
        logic              known;
        logic [POS_W-1:0]  pos;
        logic              bad;
        logic              fend;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bfhp_byte_if   byte_ch ();
    bfhp_cfg_if    cfg_ch ();
    bfhp_result_if res_ch ();

    bus_frame_header_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    // Parser copy: configuration and frame state
    logic [ADDR_W-1:0] node_addr_cfg;
    logic [BYTE_W-1:0] start_mark_cfg;
    logic [POS_W-1:0]  frame_pos;
    logic [ADDR_W-1:0] sender_reg;
    logic [ADDR_W-1:0] receiver_reg;
    logic [BYTE_W-1:0] frame_type_reg;
    logic [BYTE_W-1:0] length_reg;
    logic              phys_reg;
    logic              answer_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              match_reg;

    t_result parse_q [$];
    int      bad_fields;
    int      results_seen;
    int      bytes_sent;
    bit      byte_quiet;
    bit      rdy_quiet;

    // Directed frames: two bad markers, a zero-length match, a short payload
    t_dir_row dir_plan [24] = '{
        '{8'h00, 1'b1, POS_IDLE,   1'b1, 1'b0},
        '{8'h03, 1'b1, POS_MARKER, 1'b0, 1'b0},
        '{8'hFF, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hA5, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h01, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h02, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h03, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hFF, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hFF, 1'b1, POS_IDLE,   1'b0, 1'b1},
        '{8'h03, 1'b1, POS_MARKER, 1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hFF, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hFF, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hFF, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h02, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h00, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'hAA, 1'b0, POS_IDLE,   1'b0, 1'b0},
        '{8'h55, 1'b1, POS_IDLE,   1'b0, 1'b1},
        '{8'hFF, 1'b1, POS_IDLE,   1'b1, 1'b0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // Return the parser copy to its reset state
    function automatic void reset_parser_copy();
        node_addr_cfg  = NODE_ADDRESS_RST;
        start_mark_cfg = START_MARKER_RST;
        frame_pos      = POS_IDLE;
        sender_reg     = '0;
        receiver_reg   = '0;
        frame_type_reg = '0;
        length_reg     = '0;
        phys_reg       = 1'b0;
        answer_reg     = 1'b0;
        prio_reg       = '0;
        match_reg      = 1'b0;
    endfunction

    // Advance the frame by one byte and build the result it shows
    function automatic t_result parse_bus_byte(input logic [BYTE_W-1:0] b);
        t_result          r;
        logic [POS_W-1:0] pos;
        logic             bad;
        logic             hdr;
        logic             pay;
        logic             fend;
        logic             shown;
        pos  = frame_pos + POS_W'(1);
        bad  = 1'b0;
        hdr  = 1'b0;
        pay  = 1'b0;
        fend = 1'b0;
        case (pos)
            POS_MARKER:   bad = (b != start_mark_cfg);
            POS_SENDER_0: sender_reg[23:16] = b;
            POS_SENDER_1: sender_reg[15:8]  = b;
            POS_SENDER_2: sender_reg[7:0]   = b;
            POS_RECV_0:   receiver_reg[23:16] = b;
            POS_RECV_1:   receiver_reg[15:8]  = b;
            POS_RECV_2: begin
                receiver_reg[7:0] = b;
                if (receiver_reg == node_addr_cfg)
                    match_reg = 1'b1;
            end
            POS_TYPE:     frame_type_reg = b;
            POS_LENGTH:   length_reg = b;
            default: begin
                if (pos >= POS_FLAGS) begin
                    if (pos == POS_FLAGS) begin
                        phys_reg   = b[FLAG_PHYS_BIT];
                        answer_reg = b[FLAG_ANSWER_BIT];
                        prio_reg   = {1'b0, b[0]} + {1'b0, b[1]} + {1'b0, b[2]};
                        hdr        = 1'b1;
                    end else begin
                        pay = 1'b1;
                    end
                    if (pos >= POS_W'(length_reg) + POS_FLAGS)
                        fend = 1'b1;
                end
            end
        endcase
        shown = match_reg;
        // Drop the frame on a bad marker, close it on the last byte
        if (bad || fend) begin
            frame_pos = POS_IDLE;
            match_reg = 1'b0;
        end else begin
            frame_pos = pos;
        end
        r.frame_position   = frame_pos;
        r.bad_marker       = bad;
        r.header_done      = hdr;
        r.payload_valid    = pay;
        r.frame_end        = fend;
        r.id_match         = shown;
        r.sender_address   = sender_reg;
        r.frame_type       = frame_type_reg;
        r.payload_length   = length_reg;
        r.address_physical = phys_reg;
        r.answer_expected  = answer_reg;
        r.priority_level   = prio_reg;
        return r;
    endfunction

    // Draw an idle gap; toggle into and out of gap-free stretches now and then
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : int'($urandom_range(0, 9));
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (bad_fields < MAX_PRINTS)
            $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
        bad_fields++;
    endtask

    // Send one byte request and queue its predicted result on acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_wait(byte_quiet);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid    <= 1'b1;
        byte_ch.bus_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        parse_q.push_back(parse_bus_byte(b));
        bytes_sent++;
    endtask

    task automatic send_addr(input logic [ADDR_W-1:0] a);
        send_byte(a[23:16]);
        send_byte(a[15:8]);
        send_byte(a[7:0]);
    endtask

    // Well-formed frame with the given payload length and random content
    task automatic send_good_frame(input logic [BYTE_W-1:0] len);
        logic [ADDR_W-1:0] recv;
        case ($urandom_range(0, 3))
            0, 1:    recv = node_addr_cfg;
            2:       recv = node_addr_cfg ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
            default: recv = ADDR_W'($urandom);
        endcase
        send_byte(start_mark_cfg);
        send_addr(ADDR_W'($urandom));
        send_addr(recv);
        send_byte(BYTE_W'($urandom));
        send_byte(len);
        send_byte(BYTE_W'($urandom));
        repeat (int'(len)) send_byte(BYTE_W'($urandom));
    endtask

    // Mostly short frames, rarely long ones, plus noise and cut-off headers
    task automatic send_random_frame();
        int               pick;
        logic [BYTE_W-1:0] len;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
        end else if (pick == 1) begin
            send_byte(start_mark_cfg);
            repeat ($urandom_range(1, 12)) send_byte(BYTE_W'($urandom));
        end else begin
            case ($urandom_range(0, 99))
                0:       len = 8'hFF;
                1, 2:    len = BYTE_W'($urandom);
                default: len = BYTE_W'($urandom_range(0, 6));
            endcase
            send_good_frame(len);
        end
    endtask

    // Write one configuration register request
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        int gap;
        gap = draw_wait(byte_quiet);
        if (gap > 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_NODE_ADDRESS: node_addr_cfg  = data;
            CFG_START_MARKER: start_mark_cfg = data[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // Wait on the clock until every queued result has come back
    task automatic wait_drain();
        do @(posedge i_clk); while (parse_q.size() != 0);
    endtask

    // Result side: random stalls between reads
    initial begin : result_reader
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(rdy_quiet);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (parse_q.size() == 0) begin
                flag_mismatch("result with none pending", 1, 0);
            end else begin
                want = parse_q.pop_front();
                if (res_ch.frame_position != want.frame_position)
                    flag_mismatch("frame_position", res_ch.frame_position,
                                  want.frame_position);
                if (res_ch.bad_marker != want.bad_marker)
                    flag_mismatch("bad_marker", res_ch.bad_marker, want.bad_marker);
                if (res_ch.header_done != want.header_done)
                    flag_mismatch("header_done", res_ch.header_done, want.header_done);
                if (res_ch.payload_valid != want.payload_valid)
                    flag_mismatch("payload_valid", res_ch.payload_valid, want.payload_valid);
                if (res_ch.frame_end != want.frame_end)
                    flag_mismatch("frame_end", res_ch.frame_end, want.frame_end);
                if (res_ch.id_match != want.id_match)
                    flag_mismatch("id_match", res_ch.id_match, want.id_match);
                if (res_ch.sender_address != want.sender_address)
                    flag_mismatch("sender_address", res_ch.sender_address,
                                  want.sender_address);
                if (res_ch.frame_type != want.frame_type)
                    flag_mismatch("frame_type", res_ch.frame_type, want.frame_type);
                if (res_ch.payload_length != want.payload_length)
                    flag_mismatch("payload_length", res_ch.payload_length,
                                  want.payload_length);
                if (res_ch.address_physical != want.address_physical)
                    flag_mismatch("address_physical", res_ch.address_physical,
                                  want.address_physical);
                if (res_ch.answer_expected != want.answer_expected)
                    flag_mismatch("answer_expected", res_ch.answer_expected,
                                  want.answer_expected);
                if (res_ch.priority_level != want.priority_level)
                    flag_mismatch("priority_level", res_ch.priority_level,
                                  want.priority_level);
            end
        end
    end

    // Main sequence: reset, directed table, then randomized phases
    initial begin : stimulus
        logic [ADDR_W-1:0] node_val;
        logic [BYTE_W-1:0] mark_val;
        i_rst_n          <= 1'b0;
        byte_ch.valid    <= 1'b0;
        byte_ch.bus_byte <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_NODE_ADDRESS;
        cfg_ch.data      <= '0;
        bad_fields   = 0;
        results_seen = 0;
        bytes_sent   = 0;
        byte_quiet   = 1'b0;
        rdy_quiet    = 1'b0;
        reset_parser_copy();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; pin the obvious fields to typed values
        foreach (dir_plan[i]) begin
            send_byte(dir_plan[i].bus_byte);
            if (dir_plan[i].known) begin
                parse_q[$].frame_position = dir_plan[i].pos;
                parse_q[$].bad_marker     = dir_plan[i].bad;
                parse_q[$].frame_end      = dir_plan[i].fend;
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            byte_ch.valid <= 1'b0;
            wait_drain();
            // Pick extremes first, then the reset values, then random settings
            case (ph)
                0: begin
                    node_val = '0;
                    mark_val = '0;
                end
                1: begin
                    node_val = '1;
                    mark_val = '1;
                end
                2: begin
                    node_val = NODE_ADDRESS_RST;
                    mark_val = START_MARKER_RST;
                end
                default: begin
                    node_val = ADDR_W'($urandom);
                    mark_val = BYTE_W'($urandom);
                end
            endcase
            write_reg(CFG_SPARE_2, ADDR_W'($urandom));
            write_reg(CFG_NODE_ADDRESS, node_val);
            write_reg(CFG_START_MARKER, mark_val);
            write_reg(CFG_SPARE_3, ADDR_W'($urandom));
            cfg_ch.valid <= 1'b0;

            if (ph == 1)
                send_good_frame(8'hFF);
            while (bytes_sent < (ph + 1) * BYTES_PER_PHASE)
                send_random_frame();
        end

        byte_ch.valid <= 1'b0;
        wait_drain();
        repeat (12) @(posedge i_clk);
        if (bad_fields == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bfhp_pkg.sv
rtl/core/bfhp_ifs.sv
rtl/core/bfhp_cfg_regs.sv
rtl/core/bfhp_parse.sv
rtl/core/bfhp_out_reg.sv
rtl/core/bus_frame_header_parser.sv
rtl/core/bfhp_checker.sv
sim/tb.sv
